>>> sv/crgs_pkg.sv
// ----------------------------------------------------------------------------
// crgs_pkg
// Shared types and fixed field widths of the coordinate row-grouping sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package crgs_pkg;

	// Fixed widths of the stream fields.
	localparam int PORT_IDX_W = 16;
	localparam int VALUE_W    = 32;
	localparam int TDATA_W    = 64;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_TEST,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_EMIT_RD,
		ST_EMIT_WAIT
	} state_t;

	// Result hand-off from the sequencer to the output register.
	typedef struct packed {
		logic valid;
		logic last;
		logic ovf;
	} emit_t;

endpackage

`default_nettype wire

>>> sv/crgs_store.sv
// ----------------------------------------------------------------------------
// crgs_store
// Entry memory: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module crgs_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int W     = 64
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> sv/crgs_seq.sv
// ----------------------------------------------------------------------------
// crgs_seq
// Sequencer: loads entries, regroups those with rows below the entry count by row in memory, then reads them out.
// ----------------------------------------------------------------------------
`default_nettype none

module crgs_seq #(
	parameter int MAX_ENTRIES = 64,
	parameter int SW          = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    s_valid,
	output logic                                         s_ready,
	input  wire logic [2*SW+crgs_pkg::VALUE_W-1:0]       s_entry,
	input  wire logic                                    s_last,
	input  wire logic                                    out_free,
	output crgs_pkg::emit_t                              emit,
	output logic                                         we,
	output logic [$clog2(MAX_ENTRIES)-1:0]               waddr,
	output logic [2*SW+crgs_pkg::VALUE_W-1:0]            wdata,
	output logic [$clog2(MAX_ENTRIES)-1:0]               raddr,
	input  wire logic [2*SW+crgs_pkg::VALUE_W-1:0]       rdata
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int W  = 2 * SW + crgs_pkg::VALUE_W;
	localparam int XW = (SW > CW) ? SW : CW;

	crgs_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [CW-1:0] r_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] fill_q;
	logic [W-1:0]  hold_q;

	logic [CW-1:0] k_inc;
	logic [CW-1:0] r_inc;
	logic [CW-1:0] fill_inc;
	logic [CW-1:0] fill_new;
	logic          match;
	logic          scan_end;
	logic          done;
	logic          has_room;
	logic          accept;

	assign k_inc    = k_q + CW'(1);
	assign r_inc    = r_q + CW'(1);
	assign fill_inc = fill_q + CW'(1);
	assign match    = (XW'(rdata[SW-1:0]) == XW'(r_q));
	assign has_room = (count_q < CW'(MAX_ENTRIES));
	assign accept   = s_valid && s_ready;

	// The fill point moves on a swap and on a match already in place.
	assign fill_new = ((state_q == crgs_pkg::ST_SWAP_B) ||
		((state_q == crgs_pkg::ST_TEST) && match && (k_q == fill_q))) ? fill_inc : fill_q;
	assign scan_end = (k_inc == count_q);
	assign done     = scan_end && ((r_inc == count_q) || (fill_new == count_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			crgs_pkg::ST_LOAD: begin
				if (accept && s_last) begin
					state_d = crgs_pkg::ST_SCAN;
				end
			end
			crgs_pkg::ST_SCAN: begin
				state_d = crgs_pkg::ST_TEST;
			end
			crgs_pkg::ST_TEST: begin
				if (match && (k_q != fill_q)) begin
					state_d = crgs_pkg::ST_SWAP_A;
				end else if (done) begin
					state_d = crgs_pkg::ST_EMIT_RD;
				end else begin
					state_d = crgs_pkg::ST_SCAN;
				end
			end
			crgs_pkg::ST_SWAP_A: begin
				state_d = crgs_pkg::ST_SWAP_B;
			end
			crgs_pkg::ST_SWAP_B: begin
				state_d = done ? crgs_pkg::ST_EMIT_RD : crgs_pkg::ST_SCAN;
			end
			crgs_pkg::ST_EMIT_RD: begin
				state_d = crgs_pkg::ST_EMIT_WAIT;
			end
			crgs_pkg::ST_EMIT_WAIT: begin
				if (out_free) begin
					state_d = scan_end ? crgs_pkg::ST_LOAD : crgs_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_d = crgs_pkg::ST_LOAD;
			end
		endcase
	end

	// Memory controls and handshake outputs.
	always_comb begin
		s_ready    = 1'b0;
		we         = 1'b0;
		waddr      = k_q[AW-1:0];
		wdata      = rdata;
		raddr      = k_q[AW-1:0];
		emit.valid = 1'b0;
		emit.last  = scan_end;
		emit.ovf   = ovf_q;
		unique case (state_q)
			crgs_pkg::ST_LOAD: begin
				s_ready = 1'b1;
				we      = s_valid && has_room;
				waddr   = count_q[AW-1:0];
				wdata   = s_entry;
			end
			crgs_pkg::ST_SCAN: begin
				raddr = k_q[AW-1:0];
			end
			crgs_pkg::ST_TEST: begin
				// Fetch the slot at the fill point in case a swap follows.
				raddr = fill_q[AW-1:0];
			end
			crgs_pkg::ST_SWAP_A: begin
				we    = 1'b1;
				waddr = k_q[AW-1:0];
				wdata = rdata;
			end
			crgs_pkg::ST_SWAP_B: begin
				we    = 1'b1;
				waddr = fill_q[AW-1:0];
				wdata = hold_q;
			end
			crgs_pkg::ST_EMIT_RD: begin
				raddr = k_q[AW-1:0];
			end
			crgs_pkg::ST_EMIT_WAIT: begin
				raddr      = k_q[AW-1:0];
				emit.valid = out_free;
			end
			default: begin
				s_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crgs_pkg::ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
			r_q     <= '0;
			k_q     <= '0;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				crgs_pkg::ST_LOAD: begin
					if (accept) begin
						if (has_room) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						r_q    <= '0;
						k_q    <= '0;
						fill_q <= '0;
					end
				end
				crgs_pkg::ST_TEST, crgs_pkg::ST_SWAP_B: begin
					if (!((state_q == crgs_pkg::ST_TEST) && match && (k_q != fill_q))) begin
						fill_q <= fill_new;
						if (done) begin
							k_q <= '0;
						end else if (scan_end) begin
							r_q <= r_inc;
							k_q <= fill_new;
						end else begin
							k_q <= k_inc;
						end
					end
				end
				crgs_pkg::ST_EMIT_WAIT: begin
					if (out_free) begin
						if (scan_end) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end else begin
							k_q <= k_inc;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Entry found away from the fill point waits here for the second write.
	always_ff @(posedge clk) begin
		if ((state_q == crgs_pkg::ST_TEST) && match && (k_q != fill_q)) begin
			hold_q <= rdata;
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_behind_scan: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == crgs_pkg::ST_SCAN) || (state_q == crgs_pkg::ST_TEST)) |->
		((fill_q <= k_q) && (k_q < count_q)))
		else $error("scan index left the range between fill point and count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above capacity");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> (out_free && !s_ready))
		else $error("result handed over while output register busy or loading");

	a_sort_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == crgs_pkg::ST_LOAD) && accept && s_last) |=> (count_q != '0))
		else $error("sort started on an empty store");
`endif

endmodule

`default_nettype wire

>>> sv/coo_row_grouping_sort.sv
// ----------------------------------------------------------------------------
// coo_row_grouping_sort
// Buffers sparse-matrix coordinate entries, regroups those whose row number is
// below the entry count by row in place, and streams them back out.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Payload                                          Marker
// s_axis    in   tdata: row_index, col_index, entry_value          tlast: last_entry
// m_axis    out  tdata: out_row, out_col, out_value                tlast: out_last,
//                                                                  tuser: overflow
//
// While loading, the block is always ready for input. When the transfer marked
// last arrives, the block stops accepting and regroups the stored set: each scan
// step addresses the memory, then compares against the registered read data,
// and each swap adds two writes through the single write port. For n entries
// the sort costs up to about n*n scan steps, bounded by the one-read, one-write
// memory port. Emission then reads each entry and hands it over once the output
// register is free, and input is accepted again after the final result reaches
// the output register. A stalled output simply holds the sequencer in its emit
// wait state. Reset clears control state only; the entry memory is never
// cleared, since only slots already written are read.
// ----------------------------------------------------------------------------
`default_nettype none

module coo_row_grouping_sort #(
	parameter int MAX_ENTRIES = 64,
	parameter int INDEX_BITS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// row_index [15:0], col_index [31:16], entry_value [63:32]
	input  wire logic [63:0] s_axis_tdata,
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// out_row [15:0], out_col [31:16], out_value [63:32]
	output logic [63:0]      m_axis_tdata,
	output logic             m_axis_tlast,
	// overflow [0]
	output logic             m_axis_tuser
);

	// Stored index width: indexes are masked to INDEX_BITS, and the ports carry
	// only 16 bits, so wider settings need no extra storage.
	localparam int SW = (INDEX_BITS < crgs_pkg::PORT_IDX_W) ? INDEX_BITS : crgs_pkg::PORT_IDX_W;
	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int W  = 2 * SW + crgs_pkg::VALUE_W;

	logic [W-1:0]       s_entry;
	logic [W-1:0]       rdata;
	logic [W-1:0]       wdata;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr;
	logic               we;
	logic               out_free;
	crgs_pkg::emit_t    emit;

	logic               m_valid_q;
	logic [63:0]        m_data_q;
	logic               m_last_q;
	logic               m_user_q;

	// Entry layout in memory: value on top, then column, row in the low bits.
	assign s_entry = {s_axis_tdata[63:32], s_axis_tdata[16 +: SW], s_axis_tdata[0 +: SW]};

	crgs_seq #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.SW          (SW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_axis_tvalid),
		.s_ready  (s_axis_tready),
		.s_entry  (s_entry),
		.s_last   (s_axis_tlast),
		.out_free (out_free),
		.emit     (emit),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.raddr    (raddr),
		.rdata    (rdata)
	);

	crgs_store #(
		.DEPTH (MAX_ENTRIES),
		.AW    (AW),
		.W     (W)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Output register: takes a new result when empty or when the current one
	// is being taken in the same cycle.
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			m_data_q <= {rdata[W-1 -: crgs_pkg::VALUE_W],
				crgs_pkg::PORT_IDX_W'(rdata[SW +: SW]),
				crgs_pkg::PORT_IDX_W'(rdata[0 +: SW])};
			m_last_q <= emit.last;
			m_user_q <= emit.ovf;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire
